// ----- hw/rtl/thp_pkg.sv -----
// Shared types and constants of the sensor compensation pipeline.
package thp_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_TEMP    = 3'd0;
    localparam logic [2:0] CFG_PRESS_A = 3'd1;
    localparam logic [2:0] CFG_PRESS_B = 3'd2;
    localparam logic [2:0] CFG_PRESS_C = 3'd3;
    localparam logic [2:0] CFG_HUM_A   = 3'd4;
    localparam logic [2:0] CFG_HUM_B   = 3'd5;

    // Divider depth: one quotient bit per stage
    localparam int DIV_STAGES = 64;
    localparam int DIV_DEN_W  = 31;

    // Formula constants
    localparam logic signed [31:0] HUM_LIMIT    = 32'sd419430400;
    localparam logic signed [63:0] PRESS_OFFSET = 64'sh0000_8000_0000_0000;

    // Fields that ride along with the divider
    typedef struct packed {
        logic signed [31:0] temp;
        logic [16:0]        hum;
        logic               dz;
        logic               negq;
    } t_side;

endpackage

// ----- hw/rtl/thp_stream_if.sv -----
// Valid/ready channels for raw sample words and compensated result words.
interface thp_in_if import thp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;

    modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
    modport sink   (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface thp_out_if import thp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centideg;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               divisor_zero;

    modport source (output valid, temperature_centideg, pressure_q24_8, humidity_q22_10,
                    divisor_zero, input ready);
    modport sink   (input valid, temperature_centideg, pressure_q24_8, humidity_q22_10,
                    divisor_zero, output ready);
endinterface

// ----- hw/rtl/thp_udiv.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module thp_udiv import thp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  logic [63:0]          i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [63:0]          o_quo,
    output t_side                o_side
);

    logic [DIV_STAGES-1:0] r_v;
    logic [63:0]           r_q   [DIV_STAGES];
    logic [DIV_DEN_W-1:0]  r_rem [DIV_STAGES];
    logic [DIV_DEN_W-1:0]  r_den [DIV_STAGES];
    t_side                 r_side[DIV_STAGES];

    // Shift valid bits along with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[DIV_STAGES-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [63:0]          c_q_in;
        logic [DIV_DEN_W-1:0] c_rem_in;
        logic [DIV_DEN_W-1:0] c_den_in;
        t_side                c_side_in;
        logic [DIV_DEN_W:0]   c_trial;
        logic                 c_fit;

        if (k == 0) begin : g_first
            assign c_q_in    = i_num;
            assign c_rem_in  = '0;
            assign c_den_in  = i_den;
            assign c_side_in = i_side;
        end else begin : g_next
            assign c_q_in    = r_q[k-1];
            assign c_rem_in  = r_rem[k-1];
            assign c_den_in  = r_den[k-1];
            assign c_side_in = r_side[k-1];
        end

        // Bring down the next dividend bit and try the subtract
        assign c_trial = {c_rem_in, c_q_in[63]};
        assign c_fit   = c_trial >= {1'b0, c_den_in};

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_q[k]    <= {c_q_in[62:0], c_fit};
                r_rem[k]  <= c_fit ? DIV_DEN_W'(c_trial - {1'b0, c_den_in})
                                   : c_trial[DIV_DEN_W-1:0];
                r_den[k]  <= c_den_in;
                r_side[k] <= c_side_in;
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quo   = r_q[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

    // Final remainder stays below a nonzero divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[DIV_STAGES-1] && (r_den[DIV_STAGES-1] != '0)
        |-> r_rem[DIV_STAGES-1] < r_den[DIV_STAGES-1])
        else $error("divider remainder not below divisor");

endmodule

// ----- hw/rtl/thp_sensor_compensation_core.sv -----
// Top level: temperature, pressure and humidity compensation pipeline.
// A raw word passes the capture stage, the front stages, the divider and the post stages, in that order.
// Throughput: one word per cycle when not stalled; the 64-stage pressure divider sets the depth.
// Stalls freeze the whole pipeline; an empty first stage still takes a word.
// Reset (synchronous, active low) clears all valid bits and the calibration
// registers to zero; no clearing pass is needed.
module thp_sensor_compensation_core import thp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    thp_in_if.sink      i_raw,
    thp_out_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata
);

    // Calibration registers
    logic [47:0] r_temp_calib;
    logic [63:0] r_press_calib_a;
    logic [63:0] r_press_calib_b;
    logic [15:0] r_press_calib_c;
    logic [31:0] r_hum_calib_a;
    logic [31:0] r_hum_calib_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib    <= '0;
            r_press_calib_a <= '0;
            r_press_calib_b <= '0;
            r_press_calib_c <= '0;
            r_hum_calib_a   <= '0;
            r_hum_calib_b   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEMP:    r_temp_calib    <= i_cfg_wdata[47:0];
                CFG_PRESS_A: r_press_calib_a <= i_cfg_wdata;
                CFG_PRESS_B: r_press_calib_b <= i_cfg_wdata;
                CFG_PRESS_C: r_press_calib_c <= i_cfg_wdata[15:0];
                CFG_HUM_A:   r_hum_calib_a   <= i_cfg_wdata[31:0];
                CFG_HUM_B:   r_hum_calib_b   <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Unpack coefficients
    logic [15:0]        c_t1;
    logic signed [31:0] c_t2, c_t3;
    logic signed [15:0] c_p2, c_p5;
    logic signed [63:0] c_p1, c_p3, c_p4, c_p6, c_p7, c_p8, c_p9;
    logic signed [31:0] c_h1, c_h2, c_h3, c_h4, c_h5, c_h6;

    assign c_t1 = r_temp_calib[15:0];
    assign c_t2 = {{16{r_temp_calib[31]}}, r_temp_calib[31:16]};
    assign c_t3 = {{16{r_temp_calib[47]}}, r_temp_calib[47:32]};
    assign c_p1 = {48'd0, r_press_calib_a[15:0]};
    assign c_p2 = r_press_calib_a[31:16];
    assign c_p3 = {{48{r_press_calib_a[47]}}, r_press_calib_a[47:32]};
    assign c_p4 = {{48{r_press_calib_a[63]}}, r_press_calib_a[63:48]};
    assign c_p5 = r_press_calib_b[15:0];
    assign c_p6 = {{48{r_press_calib_b[31]}}, r_press_calib_b[31:16]};
    assign c_p7 = {{48{r_press_calib_b[47]}}, r_press_calib_b[47:32]};
    assign c_p8 = {{48{r_press_calib_b[63]}}, r_press_calib_b[63:48]};
    assign c_p9 = {{48{r_press_calib_c[15]}}, r_press_calib_c};
    assign c_h1 = {24'd0, r_hum_calib_a[7:0]};
    assign c_h2 = {{16{r_hum_calib_a[23]}}, r_hum_calib_a[23:8]};
    assign c_h3 = {24'd0, r_hum_calib_a[31:24]};
    assign c_h4 = {{20{r_hum_calib_b[11]}}, r_hum_calib_b[11:0]};
    assign c_h5 = {{20{r_hum_calib_b[23]}}, r_hum_calib_b[23:12]};
    assign c_h6 = {{24{r_hum_calib_b[31]}}, r_hum_calib_b[31:24]};

    // Flow control
    logic [9:0] r_vpre;
    logic [4:0] r_vpost;
    logic       c_adv;
    logic       c_in_ready;
    logic       w_div_valid;

    assign c_adv      = !r_vpost[4] || o_res.ready;
    assign c_in_ready = c_adv || !r_vpre[0];
    assign i_raw.ready = c_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpre  <= '0;
            r_vpost <= '0;
        end else begin
            if (c_in_ready) begin
                r_vpre[0] <= i_raw.valid;
            end
            if (c_adv) begin
                r_vpre[9:1] <= r_vpre[8:0];
                r_vpost     <= {r_vpost[3:0], w_div_valid};
            end
        end
    end

    // Stage 0: capture raw word
    logic [19:0] r0_rt, r0_rp;
    logic [15:0] r0_rh;

    always_ff @(posedge i_clk) begin
        if (c_in_ready) begin
            r0_rt <= i_raw.raw_temperature;
            r0_rp <= i_raw.raw_pressure;
            r0_rh <= i_raw.raw_humidity;
        end
    end

    // Temperature terms
    logic signed [31:0] c_ta_a, c_ta_d;
    assign c_ta_a = $signed({15'd0, r0_rt[19:3]}) - $signed({15'd0, c_t1, 1'b0});
    assign c_ta_d = $signed({16'd0, r0_rt[19:4]}) - $signed({16'd0, c_t1});

    logic signed [31:0] r1_ta, r1_tdd, r2_tas, r2_tb, r3_fine;
    logic [19:0]        r1_rp, r2_rp, r3_rp;
    logic [15:0]        r1_rh, r2_rh, r3_rh;

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r1_ta   <= c_ta_a * c_t2;
            r1_tdd  <= c_ta_d * c_ta_d;
            r1_rp   <= r0_rp;
            r1_rh   <= r0_rh;
            r2_tas  <= r1_ta >>> 11;
            r2_tb   <= (r1_tdd >>> 12) * c_t3;
            r2_rp   <= r1_rp;
            r2_rh   <= r1_rh;
            r3_fine <= r2_tas + (r2_tb >>> 14);
            r3_rp   <= r2_rp;
            r3_rh   <= r2_rh;
        end
    end

    // Stage 4: temperature out, first pressure and humidity products
    logic signed [33:0] c_v1;
    logic signed [67:0] c_sq;
    logic signed [49:0] c_m5, c_m2;
    logic signed [31:0] c_hv;

    assign c_v1 = 34'(r3_fine) - 34'sd128000;
    assign c_sq = c_v1 * c_v1;
    assign c_m5 = c_v1 * c_p5;
    assign c_m2 = c_v1 * c_p2;
    assign c_hv = r3_fine - 32'sd76800;

    logic signed [31:0] r4_temp, r5_temp, r6_temp, r7_temp, r8_temp, r9_temp;
    logic signed [63:0] r4_sq, r4_m5, r4_m2, r5_a6, r5_a3, r5_m5, r5_m2;
    logic signed [63:0] r6_v2, r6_v1a, r7_v1b, r7_num0, r8_num;
    logic signed [DIV_DEN_W-1:0] r8_den;
    logic [63:0]        r9_un;
    logic [DIV_DEN_W-1:0] r9_ud;
    logic               r9_negq, r9_dz;
    logic [19:0]        r4_rp, r5_rp, r6_rp;
    logic [15:0]        r4_rh;
    logic signed [31:0] r4_hm1, r4_hm6, r4_hm3, r5_hx, r5_hy1, r6_hx, r6_hy3a;
    logic signed [31:0] r7_hvv, r8_hvv, r8_hsq, r9_hvv, r9_hth;

    logic signed [63:0] c_pp, c_den_full;
    logic signed [31:0] c_hy3, c_hs;

    assign c_pp       = 64'sd1048576 - $signed({44'd0, r6_rp});
    assign c_den_full = r7_v1b >>> 33;
    assign c_hy3      = (r6_hy3a + 32'sd8192) >>> 14;
    assign c_hs       = r7_hvv >>> 15;

    // Stages 4 to 9: pressure divisor and dividend, humidity lane beside it
    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r4_temp <= (r3_fine * 32'sd5 + 32'sd128) >>> 8;
            r4_sq   <= c_sq[63:0];
            r4_m5   <= 64'(c_m5);
            r4_m2   <= 64'(c_m2);
            r4_rp   <= r3_rp;
            r4_rh   <= r3_rh;
            r4_hm1  <= c_h5 * c_hv;
            r4_hm6  <= c_hv * c_h6;
            r4_hm3  <= c_hv * c_h3;

            r5_temp <= r4_temp;
            r5_a6   <= r4_sq * c_p6;
            r5_a3   <= r4_sq * c_p3;
            r5_m5   <= r4_m5;
            r5_m2   <= r4_m2;
            r5_rp   <= r4_rp;
            r5_hx   <= ($signed({2'd0, r4_rh, 14'd0}) - (c_h4 <<< 20) - r4_hm1
                        + 32'sd16384) >>> 15;
            r5_hy1  <= (r4_hm6 >>> 10) * ((r4_hm3 >>> 11) + 32'sd32768);

            r6_temp <= r5_temp;
            r6_v2   <= r5_a6 + (r5_m5 <<< 17) + (c_p4 <<< 35);
            r6_v1a  <= (r5_a3 >>> 8) + (r5_m2 <<< 12) + PRESS_OFFSET;
            r6_rp   <= r5_rp;
            r6_hx   <= r5_hx;
            r6_hy3a <= ((r5_hy1 >>> 10) + 32'sd2097152) * c_h2;

            r7_temp <= r6_temp;
            r7_v1b  <= r6_v1a * c_p1;
            r7_num0 <= (c_pp <<< 31) - r6_v2;
            r7_hvv  <= r6_hx * c_hy3;

            r8_temp <= r7_temp;
            r8_den  <= c_den_full[DIV_DEN_W-1:0];
            r8_num  <= r7_num0 * 64'sd3125;
            r8_hvv  <= r7_hvv;
            r8_hsq  <= c_hs * c_hs;

            r9_temp <= r8_temp;
            r9_un   <= r8_num[63] ? 64'(-r8_num) : r8_num;
            r9_ud   <= r8_den[DIV_DEN_W-1] ? DIV_DEN_W'(-r8_den) : r8_den;
            r9_negq <= r8_num[63] ^ r8_den[DIV_DEN_W-1];
            r9_dz   <= r8_den == '0;
            r9_hvv  <= r8_hvv;
            r9_hth  <= (r8_hsq >>> 7) * c_h1;
        end
    end

    // Finish humidity with clamp and pack the side word
    logic signed [31:0] c_hfin, c_hclamp;
    t_side              c_side;

    assign c_hfin = r9_hvv - (r9_hth >>> 4);

    always_comb begin
        if (c_hfin[31]) begin
            c_hclamp = '0;
        end else if (c_hfin > HUM_LIMIT) begin
            c_hclamp = HUM_LIMIT;
        end else begin
            c_hclamp = c_hfin;
        end
        c_side.temp = r9_temp;
        c_side.hum  = c_hclamp[28:12];
        c_side.dz   = r9_dz;
        c_side.negq = r9_negq;
    end

    // Quotient magnitude
    logic [63:0] w_quo;
    t_side       w_side;

    thp_udiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (c_adv),
        .i_valid (r_vpre[9]),
        .i_num   (r9_un),
        .i_den   (r9_ud),
        .i_side  (c_side),
        .o_valid (w_div_valid),
        .o_quo   (w_quo),
        .o_side  (w_side)
    );

    // Post stages: sign, correction products, final sum
    logic signed [63:0] r_q1, r_q2, r_q2_s, r_q2_m9, r_q2_m8;
    logic signed [63:0] r_q3, r_q3_m8, r_q4, r_q4_m8, r_q4_prod;
    logic [63:0]        r_q3_ll;
    logic [31:0]        r_q3_hl, r_q3_lh;
    t_side              r_s1, r_s2, r_s3, r_s4;
    logic signed [31:0] r5_out_temp;
    logic [31:0]        r5_out_press;
    logic [16:0]        r5_out_hum;
    logic               r5_out_dz;

    logic signed [63:0] c_ps, c_pres;
    assign c_ps   = r_q1 >>> 13;
    assign c_pres = ((r_q4 + (r_q4_prod >>> 25) + (r_q4_m8 >>> 19)) >>> 8) + (c_p7 <<< 4);

    always_ff @(posedge i_clk) begin
        if (c_adv) begin
            r_q1    <= w_side.negq ? $signed(64'(-w_quo)) : $signed(w_quo);
            r_s1    <= w_side;

            r_q2    <= r_q1;
            r_q2_s  <= c_ps;
            r_q2_m9 <= c_p9 * c_ps;
            r_q2_m8 <= c_p8 * r_q1;
            r_s2    <= r_s1;

            r_q3    <= r_q2;
            r_q3_m8 <= r_q2_m8;
            r_q3_ll <= 64'(r_q2_m9[31:0]) * 64'(r_q2_s[31:0]);
            r_q3_hl <= r_q2_m9[63:32] * r_q2_s[31:0];
            r_q3_lh <= r_q2_m9[31:0] * r_q2_s[63:32];
            r_s3    <= r_s2;

            r_q4      <= r_q3;
            r_q4_m8   <= r_q3_m8;
            r_q4_prod <= r_q3_ll + {32'(r_q3_hl + r_q3_lh), 32'd0};
            r_s4      <= r_s3;

            r5_out_temp  <= r_s4.temp;
            r5_out_press <= r_s4.dz ? 32'd0 : c_pres[31:0];
            r5_out_hum   <= r_s4.hum;
            r5_out_dz    <= r_s4.dz;
        end
    end

    assign o_res.valid                = r_vpost[4];
    assign o_res.temperature_centideg = r5_out_temp;
    assign o_res.pressure_q24_8       = r5_out_press;
    assign o_res.humidity_q22_10      = r5_out_hum;
    assign o_res.divisor_zero         = r5_out_dz;

    // Zero divisor forces zero pressure
    a_dz_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.divisor_zero |-> o_res.pressure_q24_8 == 32'd0)
        else $error("pressure not zero on zero divisor");

    // Humidity stays within its clamp
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.humidity_q22_10 <= 17'd102400)
        else $error("humidity above clamp");

    // Writes to an unused index leave calibration untouched
    a_cfg_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_index > CFG_HUM_B)
        |=> $stable(r_temp_calib) && $stable(r_press_calib_a) && $stable(r_press_calib_b)
            && $stable(r_press_calib_c) && $stable(r_hum_calib_a) && $stable(r_hum_calib_b))
        else $error("unused config index changed calibration");

endmodule

// ----- tb/sv/thp_comp_checker.sv -----
// Checker for the sensor compensation core: predicts each result word and compares it.
`timescale 1ns / 1ps
module thp_comp_checker import thp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    thp_in_if           i_raw,
    thp_out_if          i_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] press;
        logic [16:0] hum;
        logic        dz;
    } t_reading;

    // Shadow calibration registers
    logic [47:0] cal_temp;
    logic [63:0] cal_press_a;
    logic [63:0] cal_press_b;
    logic [15:0] cal_press_c;
    logic [31:0] cal_hum_a;
    logic [31:0] cal_hum_b;

    t_reading readings_due[$];

    function automatic t_reading compensate(logic [19:0] raw_t, logic [19:0] raw_p,
                                            logic [15:0] raw_h);
        logic [31:0] adc_t, adc_h, t1, t2, t3, a, b, d, fine;
        logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, w;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] fine64, v1, v2, p, num, ua, ub, q, sh;
        t_reading r;
        adc_t = {12'd0, raw_t};
        adc_h = {16'd0, raw_h};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        p1 = {48'd0, cal_press_a[15:0]};
        p2 = {{48{cal_press_a[31]}}, cal_press_a[31:16]};
        p3 = {{48{cal_press_a[47]}}, cal_press_a[47:32]};
        p4 = {{48{cal_press_a[63]}}, cal_press_a[63:48]};
        p5 = {{48{cal_press_b[15]}}, cal_press_b[15:0]};
        p6 = {{48{cal_press_b[31]}}, cal_press_b[31:16]};
        p7 = {{48{cal_press_b[47]}}, cal_press_b[47:32]};
        p8 = {{48{cal_press_b[63]}}, cal_press_b[63:48]};
        p9 = {{48{cal_press_c[15]}}, cal_press_c};
        h1 = {24'd0, cal_hum_a[7:0]};
        h2 = {{16{cal_hum_a[23]}}, cal_hum_a[23:8]};
        h3 = {24'd0, cal_hum_a[31:24]};
        h4 = {{20{cal_hum_b[11]}}, cal_hum_b[11:0]};
        h5 = {{20{cal_hum_b[23]}}, cal_hum_b[23:12]};
        h6 = {{24{cal_hum_b[31]}}, cal_hum_b[31:24]};

        // Temperature and fine value
        a = (adc_t >> 3) - (t1 << 1);
        a = $signed(a * t2) >>> 11;
        d = (adc_t >> 4) - t1;
        b = $signed(d * d) >>> 12;
        b = $signed(b * t3) >>> 14;
        fine = a + b;
        r.temp = $signed(fine * 32'd5 + 32'd128) >>> 8;

        // Pressure, 64-bit wrapping; keep each arithmetic shift on its own
        fine64 = {{32{fine[31]}}, fine};
        v1 = fine64 - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        sh = $signed(v1 * v1 * p3) >>> 8;
        v1 = sh + ((v1 * p2) << 12);
        v1 = $signed(((64'd1 << 47) + v1) * p1) >>> 33;
        r.dz = (v1 == 64'd0);
        r.press = '0;
        if (!r.dz) begin
            p = 64'd1048576 - {44'd0, raw_p};
            num = ((p << 31) - v2) * 64'd3125;
            ua = num[63] ? -num : num;
            ub = v1[63] ? -v1 : v1;
            q = ua / ub;
            p = (num[63] != v1[63]) ? -q : q;
            v1 = ($signed(p) >>> 13);
            v1 = $signed(p9 * v1 * v1) >>> 25;
            v2 = $signed(p8 * p) >>> 19;
            sh = $signed(p + v1 + v2) >>> 8;
            p = sh + (p7 << 4);
            r.press = p[31:0];
        end

        // Humidity, 32-bit wrapping, then clamp
        v = fine - 32'd76800;
        x = (adc_h << 14) - (h4 << 20) - h5 * v + 32'd16384;
        x = $signed(x) >>> 15;
        y = $signed(v * h6) >>> 10;
        w = $signed(v * h3) >>> 11;
        y = y * (w + 32'd32768);
        y = $signed(y) >>> 10;
        y = y + 32'd2097152;
        y = $signed(y * h2 + 32'd8192) >>> 14;
        v = x * y;
        w = $signed(v) >>> 15;
        w = $signed(w * w) >>> 7;
        w = $signed(w * h1) >>> 4;
        v = v - w;
        if (v[31])
            v = '0;
        else if (v > HUM_LIMIT)
            v = HUM_LIMIT;
        r.hum = v[28:12];
        return r;
    endfunction

    assign o_pending = readings_due.size();

    // Track config, predict on accept, compare on delivery
    always @(posedge i_clk) begin
        t_reading want, got;
        if (!i_rst_n) begin
            cal_temp    <= '0;
            cal_press_a <= '0;
            cal_press_b <= '0;
            cal_press_c <= '0;
            cal_hum_a   <= '0;
            cal_hum_b   <= '0;
            readings_due.delete();
        end else begin
            if (i_raw.valid && i_raw.ready)
                readings_due.push_back(compensate(i_raw.raw_temperature,
                    i_raw.raw_pressure, i_raw.raw_humidity));
            if (i_res.valid && i_res.ready) begin
                got = {i_res.temperature_centideg, i_res.pressure_q24_8,
                       i_res.humidity_q22_10, i_res.divisor_zero};
                if (readings_due.size() == 0) begin
                    $display("%0t: result word with nothing expected: %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = readings_due.pop_front();
                    if (want.temp !== got.temp)
                        $display("%0t: temperature expected %0d actual %0d", $time,
                                 $signed(want.temp), $signed(got.temp));
                    if (want.press !== got.press)
                        $display("%0t: pressure expected %h actual %h", $time,
                                 want.press, got.press);
                    if (want.hum !== got.hum)
                        $display("%0t: humidity expected %0d actual %0d", $time,
                                 want.hum, got.hum);
                    if (want.dz !== got.dz)
                        $display("%0t: divisor_zero expected %b actual %b", $time,
                                 want.dz, got.dz);
                    if (want !== got)
                        o_errors <= o_errors + 1;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TEMP:    cal_temp    <= i_cfg_wdata[47:0];
                    CFG_PRESS_A: cal_press_a <= i_cfg_wdata;
                    CFG_PRESS_B: cal_press_b <= i_cfg_wdata;
                    CFG_PRESS_C: cal_press_c <= i_cfg_wdata[15:0];
                    CFG_HUM_A:   cal_hum_a   <= i_cfg_wdata[31:0];
                    CFG_HUM_B:   cal_hum_b   <= i_cfg_wdata[31:0];
                    default: ;
                endcase
            end
        end
    end

    initial o_errors = 0;

endmodule

// ----- tb/sv/tb_thp_sensor_compensation_core.sv -----
// Testbench top: drives raw sample words and calibration sets, gives the verdict.
`timescale 1ns / 1ps
module tb_thp_sensor_compensation_core;
    import thp_pkg::*;

    // Register index that maps to no calibration register
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    int          errors;
    int          pending;
    int          send_idle;
    int          recv_idle;

    thp_in_if  raw_ch ();
    thp_out_if res_ch ();

    thp_sensor_compensation_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_raw       (raw_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    thp_comp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_raw       (raw_ch),
        .i_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        raw_ch.valid = 1'b0;
        raw_ch.raw_temperature = '0;
        raw_ch.raw_pressure = '0;
        raw_ch.raw_humidity = '0;
        res_ch.ready = 1'b0;
    end

    // Stall the result side at random
    always @(posedge i_clk)
        res_ch.ready <= ($urandom_range(99) >= recv_idle);

    // Hold a raw word until it is taken; valid stays high across back-to-back words
    task automatic send_word(logic [19:0] t, logic [19:0] p, logic [15:0] h);
        if ($urandom_range(99) < send_idle) begin
            raw_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        raw_ch.valid <= 1'b1;
        raw_ch.raw_temperature <= t;
        raw_ch.raw_pressure <= p;
        raw_ch.raw_humidity <= h;
        do @(posedge i_clk); while (!raw_ch.ready);
    endtask

    // Drain, then write all six calibration registers
    task automatic load_calib(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                              logic [15:0] pc, logic [31:0] ha, logic [31:0] hb);
        raw_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TEMP;    cfg_wdata <= {16'hFFFF, tc};   @(posedge i_clk);
        cfg_index <= CFG_PRESS_A; cfg_wdata <= pa;               @(posedge i_clk);
        cfg_index <= CFG_PRESS_B; cfg_wdata <= pb;               @(posedge i_clk);
        cfg_index <= CFG_PRESS_C; cfg_wdata <= {48'hFFFF, pc};   @(posedge i_clk);
        cfg_index <= CFG_HUM_A;   cfg_wdata <= {32'hFFFF, ha};   @(posedge i_clk);
        cfg_index <= CFG_HUM_B;   cfg_wdata <= {32'hFFFF, hb};   @(posedge i_clk);
        // Out-of-range index must be ignored
        cfg_index <= CFG_UNUSED;  cfg_wdata <= {64{1'b1}};       @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Datasheet-like calibration
    task automatic load_typical();
        load_calib({16'hFC18, 16'd26435, 16'd27504},
                   {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                   {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                   16'd6000,
                   {8'd0, 16'd362, 8'd75},
                   {8'd30, 12'd50, 12'd324});
    endtask

    task automatic load_random();
        load_calib(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                   16'($urandom), $urandom, $urandom);
    endtask

    // Mostly realistic raw words, sometimes anything
    task automatic send_random();
        if ($urandom_range(3) != 0)
            send_word(20'($urandom_range(560000, 480000)),
                      20'($urandom_range(500000, 250000)),
                      16'($urandom_range(45000, 15000)));
        else
            send_word(20'($urandom), 20'($urandom), 16'($urandom));
    endtask

    task automatic run_phase(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(3))
                    0, 1: load_typical();
                    default: load_random();
                endcase
            end
            send_random();
        end
    endtask

    initial begin
        send_idle = 30;
        recv_idle = 63;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: zero divisor everywhere
        send_word('0, '0, '0);
        send_word(20'hFFFFF, 20'hFFFFF, 16'hFFFF);

        // Typical calibration across the field extremes
        load_typical();
        send_word('0, '0, '0);
        send_word(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_word(20'd519888, 20'd415148, 16'd30000);
        send_word(20'd519888, '0, 16'hFFFF);
        send_word(20'd519888, 20'hFFFFF, '0);
        send_word(20'h55555, 20'hAAAAA, 16'h5555);
        send_word(20'hAAAAA, 20'h55555, 16'hAAAA);

        // All-ones calibration
        load_calib('1, '1, '1, '1, '1, '1);
        send_word('0, '0, '0);
        send_word(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_word(20'd519888, 20'd415148, 16'd30000);

        // Most negative / most positive signed coefficients
        load_calib({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                   {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000,
                   {8'hFF, 16'h8000, 8'hFF}, {8'h80, 12'h800, 12'h800});
        send_word('0, '0, '0);
        send_word(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        load_calib({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001},
                   {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF,
                   {8'h00, 16'h7FFF, 8'h01}, {8'h7F, 12'h7FF, 12'h7FF});
        send_word('0, '0, '0);
        send_word(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_word(20'd519888, 20'd415148, 16'd30000);

        run_phase(200);

        // Let the pipeline run dry before the next phase
        raw_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        send_idle = 63;
        recv_idle = 30;
        run_phase(200);

        send_idle = 0;
        recv_idle = 0;
        run_phase(230);

        raw_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop
    initial begin
        #4ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- thp_sensor_compensation_core.f -----
hw/rtl/thp_pkg.sv
hw/rtl/thp_stream_if.sv
hw/rtl/thp_udiv.sv
hw/rtl/thp_sensor_compensation_core.sv
tb/sv/thp_comp_checker.sv
tb/sv/tb_thp_sensor_compensation_core.sv
